@@ design/trzb_pkg.sv @@
// Package for the triangle rasterizer with depth store.
// Holds widths, operation and register codes, the sequencer states and the vertex types.
// No dependencies.
`default_nettype none

package trzb_pkg;

    // Field widths of the channels.
    localparam int COORD_W    = 18;
    localparam int COLOR_W    = 32;
    localparam int PIDX_W     = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Internal arithmetic widths.
    localparam int FRAC_BITS = 14;
    localparam int ONE_Q     = 16384;
    localparam int PX_W      = 14;
    localparam int ZD_W      = 19;
    localparam int MUL_W     = 20;
    localparam int PROD_W    = 40;
    localparam int NUM_W     = 34;
    localparam int Q_W       = 20;
    localparam int WORD_W    = COLOR_W + COORD_W;

    // Default store geometry.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_DRAW  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    // Sequencer states.
    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CROSS0,
        ST_CROSS1,
        ST_CULL,
        ST_MAP,
        ST_SORT,
        ST_ROW,
        ST_IMUL,
        ST_IDIV,
        ST_IWAIT,
        ST_SPAN,
        ST_BASE,
        ST_CMUL,
        ST_CDIV,
        ST_CWAIT,
        ST_CTEST,
        ST_RD,
        ST_RDWAIT,
        ST_DONE
    } state_t;

    // Raw input vertex in Q3.14.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } raw_vert_t;

    // Vertex mapped to pixel units, depth kept raw.
    typedef struct packed {
        logic signed [PX_W-1:0]    x;
        logic signed [PX_W-1:0]    y;
        logic signed [COORD_W-1:0] z;
    } vert_t;

endpackage

`default_nettype wire

@@ design/trzb_cfg_if.sv @@
// Configuration write channel of the rasterizer.
// Depends on trzb_pkg.
`default_nettype none

interface trzb_cfg_if;
    import trzb_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/trzb_cmd_if.sv @@
// Command channel of the rasterizer: one draw, clear or read transaction.
// Depends on trzb_pkg.
`default_nettype none

interface trzb_cmd_if;
    import trzb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [COORD_W-1:0] v1_x;
    logic signed [COORD_W-1:0] v1_y;
    logic signed [COORD_W-1:0] v1_z;
    logic signed [COORD_W-1:0] v2_x;
    logic signed [COORD_W-1:0] v2_y;
    logic signed [COORD_W-1:0] v2_z;
    logic signed [COORD_W-1:0] v3_x;
    logic signed [COORD_W-1:0] v3_y;
    logic signed [COORD_W-1:0] v3_z;
    logic [COLOR_W-1:0]        fill_color;
    logic [PIDX_W-1:0]         pixel_index;

    modport source (output valid, op, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    v3_x, v3_y, v3_z, fill_color, pixel_index, input ready);
    modport sink   (input valid, op, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
                    v3_x, v3_y, v3_z, fill_color, pixel_index, output ready);
endinterface

`default_nettype wire

@@ design/trzb_res_if.sv @@
// Result channel of the rasterizer: one pixel colour and depth per command.
// Depends on trzb_pkg.
`default_nettype none

interface trzb_res_if;
    import trzb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [COLOR_W-1:0]        pixel_color;
    logic signed [COORD_W-1:0] pixel_depth;

    modport source (output valid, pixel_color, pixel_depth, input ready);
    modport sink   (input valid, pixel_color, pixel_depth, output ready);
endinterface

`default_nettype wire

@@ design/triangle_rasterizer_zbuffer_top.sv @@
// Top level of the triangle rasterizer with colour and depth stores.
// Depends on trzb_pkg, trzb_cfg_if, trzb_cmd_if, trzb_res_if, trzb_ram and trzb_rnd_div.
//
// The block takes one command at a time and returns exactly one result for it. After reset
// a pass writes zero over all MAX_WIDTH * MAX_HEIGHT entries, one per cycle; a clear
// command does the same pass. A draw does its setup, then walks the rows, skipping rows
// off screen; for every row on screen it works out the span ends, then every pixel of the
// span, a span of one column skipping the division. A shared 20x20 multiplier and a
// bit-serial rounding divider of 35 steps serve one sequencer. The command channel is not
// ready while a command is in progress; a finished result waits in an output register.
`default_nettype none

module triangle_rasterizer_zbuffer_top #(
    parameter int MAX_WIDTH  = trzb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = trzb_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic clk,
    input  wire logic rst_n,
    trzb_cfg_if.sink  cfg,
    trzb_cmd_if.sink  cmd,
    trzb_res_if.source res
);
    import trzb_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int IDX_W      = (ADDR_W > PIDX_W) ? ADDR_W : PIDX_W;
    localparam logic [CFG_DATA_W-1:0] SW_RST = CFG_DATA_W'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
    localparam logic [CFG_DATA_W-1:0] SH_RST =
        CFG_DATA_W'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);

    // Saturate a written size to [1, hi].
    function automatic logic [CFG_DATA_W-1:0] sat_size(input logic [CFG_DATA_W-1:0] v,
                                                       input int hi);
        logic [CFG_DATA_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_DATA_W'(1);
        end
        else if (int'(v) > hi)
        begin
            r = CFG_DATA_W'(hi);
        end
        return r;
    endfunction

    // Inside the unit cube test on a raw vertex.
    function automatic logic in_cube(input raw_vert_t v);
        return (v.x >= -COORD_W'(ONE_Q)) && (v.x <= COORD_W'(ONE_Q)) &&
               (v.y >= -COORD_W'(ONE_Q)) && (v.y <= COORD_W'(ONE_Q)) &&
               (v.z >= 0) && (v.z <= COORD_W'(ONE_Q));
    endfunction

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] sw_reg, sw_next, sh_reg, sh_next;

    raw_vert_t         rv0_reg, rv0_next, rv1_reg, rv1_next, rv2_reg, rv2_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [PIDX_W-1:0]  pidx_reg, pidx_next;
    logic               clr_op_reg, clr_op_next;
    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg, tmp_reg, tmp_next;
    logic signed [PROD_W:0]   cross_z;

    logic [2:0] map_cnt_reg, map_cnt_next;
    vert_t      p0_reg, p0_next, p1_reg, p1_next, p2_reg, p2_next;
    vert_t      s0_reg, s0_next, s1_reg, s1_next, s2_reg, s2_next;
    vert_t      t0, t1, t2, tt;
    logic signed [PX_W-1:0] mapped;

    logic [PX_W-1:0] d1_reg, d1_next, total_reg, total_next, seg_reg, seg_next;
    logic [PX_W-1:0] row_reg, row_next;
    logic [1:0]      k_reg, k_next;
    logic            second;
    logic signed [ZD_W-1:0]    it_diff;
    logic [PX_W-1:0]           it_r, it_den;
    logic signed [COORD_W-1:0] it_base;
    logic signed [Q_W-1:0]     it_res;
    logic signed [PX_W:0]      y_cur, sw_m1, lo_s, hi_s, col_off;
    logic                      y_ok;

    logic signed [PX_W-1:0]    ax_reg, ax_next, bx_reg, bx_next;
    logic signed [COORD_W-1:0] az_reg, az_next, bz_reg, bz_next, z_reg, z_next;
    logic [ADDR_W-1:0]         base_reg, base_next;
    logic [CFG_DATA_W-1:0]     col_reg, col_next, hi_reg, hi_next;
    logic [ADDR_W-1:0]         pix_addr;
    logic [IDX_W-1:0]          pidx_ext;

    logic [COLOR_W-1:0]        rc_reg, rc_next, out_color_reg, out_color_next;
    logic signed [COORD_W-1:0] rdp_reg, rdp_next, out_depth_reg, out_depth_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      cmd_ready;

    logic                      ram_we, ram_re;
    logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
    logic [WORD_W-1:0]         ram_wdata, ram_rdata;
    logic signed [COORD_W-1:0] rd_depth;

    logic                      div_start, div_busy, div_done;
    logic signed [NUM_W-1:0]   div_n;
    logic [PX_W-1:0]           div_d;
    logic signed [Q_W-1:0]     div_q;

    // Colour and depth share one word of the store.
    trzb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared rounding divider.
    trzb_rnd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .d     (div_d),
        .busy  (div_busy),
        .done  (div_done),
        .q     (div_q)
    );

    // Configuration writes are always taken.
    assign cfg.ready = 1'b1;
    always_comb
    begin
        sw_next = sw_reg;
        sh_next = sh_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_SCREEN_WIDTH:  sw_next = sat_size(cfg.data, MAX_WIDTH);
                REG_SCREEN_HEIGHT: sh_next = sat_size(cfg.data, MAX_HEIGHT);
                default:           ;
            endcase
        end
    end

    // Sort the mapped vertices by y.
    always_comb
    begin
        t0 = p0_reg;
        t1 = p1_reg;
        t2 = p2_reg;
        tt = p0_reg;
        if (t0.y > t1.y)
        begin
            tt = t0; t0 = t1; t1 = tt;
        end
        if (t0.y > t2.y)
        begin
            tt = t0; t0 = t2; t2 = tt;
        end
        if (t1.y > t2.y)
        begin
            tt = t1; t1 = t2; t2 = tt;
        end
    end

    // Operand selection for the four span end interpolations.
    always_comb
    begin
        second  = (row_reg > d1_reg) || (d1_reg == '0);
        it_diff = ZD_W'(s2_reg.x) - ZD_W'(s0_reg.x);
        it_r    = row_reg;
        it_den  = total_reg;
        it_base = COORD_W'(s0_reg.x);
        case (k_reg)
            2'd0:
            begin
                it_diff = ZD_W'(s2_reg.x) - ZD_W'(s0_reg.x);
                it_base = COORD_W'(s0_reg.x);
            end
            2'd1:
            begin
                it_diff = ZD_W'(s2_reg.z) - ZD_W'(s0_reg.z);
                it_base = s0_reg.z;
            end
            2'd2:
            begin
                if (second)
                begin
                    it_diff = ZD_W'(s2_reg.x) - ZD_W'(s1_reg.x);
                    it_r    = row_reg - d1_reg;
                    it_den  = seg_reg;
                    it_base = COORD_W'(s1_reg.x);
                end
                else
                begin
                    it_diff = ZD_W'(s1_reg.x) - ZD_W'(s0_reg.x);
                    it_den  = d1_reg;
                    it_base = COORD_W'(s0_reg.x);
                end
            end
            default:
            begin
                if (second)
                begin
                    it_diff = ZD_W'(s2_reg.z) - ZD_W'(s1_reg.z);
                    it_r    = row_reg - d1_reg;
                    it_den  = seg_reg;
                    it_base = s1_reg.z;
                end
                else
                begin
                    it_diff = ZD_W'(s1_reg.z) - ZD_W'(s0_reg.z);
                    it_den  = d1_reg;
                    it_base = s0_reg.z;
                end
            end
        endcase
        it_res  = Q_W'(it_base) + div_q;
        y_cur   = (PX_W+1)'(s0_reg.y) + $signed((PX_W+1)'(row_reg));
        y_ok    = !y_cur[PX_W] && (y_cur < $signed((PX_W+1)'(sh_reg)));
        sw_m1   = $signed((PX_W+1)'(sw_reg)) - (PX_W+1)'(1);
        lo_s    = ax_reg[PX_W-1] ? '0 : (PX_W+1)'(ax_reg);
        hi_s    = ((PX_W+1)'(bx_reg) < sw_m1) ? (PX_W+1)'(bx_reg) : sw_m1;
        col_off = $signed((PX_W+1)'(col_reg)) - (PX_W+1)'(ax_reg);
        cross_z = (PROD_W+1)'(tmp_reg) - (PROD_W+1)'(prod_reg);
        mapped  = $signed(prod_reg[FRAC_BITS+PX_W-1:FRAC_BITS]);
        pix_addr = base_reg + ADDR_W'(col_reg);
        pidx_ext = IDX_W'(pidx_reg);
        rd_depth = $signed(ram_rdata[COORD_W-1:0]);
    end

    // Sequencer: next state, shared unit operands and store accesses.
    always_comb
    begin
        state_next     = state_reg;
        rv0_next       = rv0_reg;
        rv1_next       = rv1_reg;
        rv2_next       = rv2_reg;
        color_next     = color_reg;
        pidx_next      = pidx_reg;
        clr_op_next    = clr_op_reg;
        clr_cnt_next   = clr_cnt_reg;
        tmp_next       = tmp_reg;
        map_cnt_next   = map_cnt_reg;
        p0_next        = p0_reg;
        p1_next        = p1_reg;
        p2_next        = p2_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        d1_next        = d1_reg;
        total_next     = total_reg;
        seg_next       = seg_reg;
        row_next       = row_reg;
        k_next         = k_reg;
        ax_next        = ax_reg;
        bx_next        = bx_reg;
        az_next        = az_reg;
        bz_next        = bz_reg;
        z_next         = z_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        hi_next        = hi_reg;
        rc_next        = rc_reg;
        rdp_next       = rdp_reg;
        out_color_next = out_color_reg;
        out_depth_next = out_depth_reg;
        out_valid_next = out_valid_reg && !res.ready;
        cmd_ready      = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;
        div_n          = NUM_W'(prod_reg);
        div_d          = it_den;
        ram_we         = 1'b0;
        ram_waddr      = pix_addr;
        ram_wdata      = {color_reg, z_reg};
        ram_re         = 1'b0;
        ram_raddr      = pix_addr;
        case (state_reg)
            // Zero pass over the whole store.
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_op_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            // Take a command transaction.
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd.valid)
                begin
                    rv0_next   = '{cmd.v1_x, cmd.v1_y, cmd.v1_z};
                    rv1_next   = '{cmd.v2_x, cmd.v2_y, cmd.v2_z};
                    rv2_next   = '{cmd.v3_x, cmd.v3_y, cmd.v3_z};
                    color_next = cmd.fill_color;
                    pidx_next  = cmd.pixel_index;
                    rc_next    = '0;
                    rdp_next   = '0;
                    clr_op_next = 1'b0;
                    case (cmd.op)
                        OP_DRAW:  state_next = ST_CROSS0;
                        OP_CLEAR:
                        begin
                            clr_op_next = 1'b1;
                            state_next  = ST_CLEAR;
                        end
                        OP_READ:  state_next = ST_RD;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            // Cross product of the edges from the first vertex.
            ST_CROSS0:
            begin
                mul_a      = MUL_W'(ZD_W'(rv1_reg.x) - ZD_W'(rv0_reg.x));
                mul_b      = MUL_W'(ZD_W'(rv2_reg.y) - ZD_W'(rv0_reg.y));
                state_next = ST_CROSS1;
            end
            ST_CROSS1:
            begin
                tmp_next   = prod_reg;
                mul_a      = MUL_W'(ZD_W'(rv1_reg.y) - ZD_W'(rv0_reg.y));
                mul_b      = MUL_W'(ZD_W'(rv2_reg.x) - ZD_W'(rv0_reg.x));
                state_next = ST_CULL;
            end
            // Back facing or zero area triangles, and those with no vertex inside the unit cube, are dropped.
            ST_CULL:
            begin
                if (!cross_z[PROD_W] ||
                    !(in_cube(rv0_reg) || in_cube(rv1_reg) || in_cube(rv2_reg)))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    map_cnt_next = '0;
                    state_next   = ST_MAP;
                end
            end
            // Map the six coordinates to pixels, one product a cycle.
            ST_MAP:
            begin
                case (map_cnt_reg)
                    3'd0:
                    begin
                        mul_a = MUL_W'(rv0_reg.x); mul_b = MUL_W'(sw_reg);
                    end
                    3'd1:
                    begin
                        p0_next.x = mapped;
                        mul_a = MUL_W'(rv0_reg.y); mul_b = MUL_W'(sh_reg);
                    end
                    3'd2:
                    begin
                        p0_next.y = mapped;
                        p0_next.z = rv0_reg.z;
                        mul_a = MUL_W'(rv1_reg.x); mul_b = MUL_W'(sw_reg);
                    end
                    3'd3:
                    begin
                        p1_next.x = mapped;
                        mul_a = MUL_W'(rv1_reg.y); mul_b = MUL_W'(sh_reg);
                    end
                    3'd4:
                    begin
                        p1_next.y = mapped;
                        p1_next.z = rv1_reg.z;
                        mul_a = MUL_W'(rv2_reg.x); mul_b = MUL_W'(sw_reg);
                    end
                    3'd5:
                    begin
                        p2_next.x = mapped;
                        mul_a = MUL_W'(rv2_reg.y); mul_b = MUL_W'(sh_reg);
                    end
                    default:
                    begin
                        p2_next.y = mapped;
                        p2_next.z = rv2_reg.z;
                        state_next = ST_SORT;
                    end
                endcase
                map_cnt_next = map_cnt_reg + 1'b1;
            end
            // Skip a triangle flat in y, else sort and set up the row walk.
            ST_SORT:
            begin
                if ((p0_reg.y == p1_reg.y) && (p0_reg.y == p2_reg.y))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    s0_next    = t0;
                    s1_next    = t1;
                    s2_next    = t2;
                    d1_next    = PX_W'(t1.y - t0.y);
                    total_next = PX_W'(t2.y - t0.y);
                    seg_next   = PX_W'(t2.y - t1.y);
                    row_next   = '0;
                    state_next = ST_ROW;
                end
            end
            // Row loop; rows off screen are skipped.
            ST_ROW:
            begin
                if (row_reg == total_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (!y_ok)
                begin
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_IMUL;
                end
            end
            // Span end interpolation: product, then rounded division.
            ST_IMUL:
            begin
                mul_a      = MUL_W'(it_diff);
                mul_b      = MUL_W'(it_r);
                state_next = ST_IDIV;
            end
            ST_IDIV:
            begin
                div_start  = 1'b1;
                state_next = ST_IWAIT;
            end
            ST_IWAIT:
            begin
                if (div_done)
                begin
                    case (k_reg)
                        2'd0:    ax_next = PX_W'(it_res);
                        2'd1:    az_next = COORD_W'(it_res);
                        2'd2:    bx_next = PX_W'(it_res);
                        default: bz_next = COORD_W'(it_res);
                    endcase
                    k_next     = k_reg + 1'b1;
                    state_next = (k_reg == 2'd3) ? ST_SPAN : ST_IMUL;
                end
            end
            // Order the span ends and form the row base address.
            ST_SPAN:
            begin
                if (ax_reg > bx_reg)
                begin
                    ax_next = bx_reg;
                    bx_next = ax_reg;
                    az_next = bz_reg;
                    bz_next = az_reg;
                end
                mul_a      = MUL_W'(y_cur);
                mul_b      = MUL_W'(sw_reg);
                state_next = ST_BASE;
            end
            ST_BASE:
            begin
                base_next = ADDR_W'(prod_reg);
                if (lo_s > hi_s)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_ROW;
                end
                else
                begin
                    col_next   = CFG_DATA_W'(lo_s);
                    hi_next    = CFG_DATA_W'(hi_s);
                    state_next = ST_CMUL;
                end
            end
            // Pixel loop: fetch stored depth while the depth is interpolated.
            ST_CMUL:
            begin
                ram_re = 1'b1;
                if (ax_reg == bx_reg)
                begin
                    z_next     = bz_reg;
                    state_next = ST_CTEST;
                end
                else
                begin
                    mul_a      = MUL_W'(ZD_W'(bz_reg) - ZD_W'(az_reg));
                    mul_b      = MUL_W'(col_off);
                    state_next = ST_CDIV;
                end
            end
            ST_CDIV:
            begin
                div_start  = 1'b1;
                div_d      = PX_W'(bx_reg - ax_reg);
                state_next = ST_CWAIT;
            end
            ST_CWAIT:
            begin
                if (div_done)
                begin
                    z_next     = COORD_W'(Q_W'(az_reg) + div_q);
                    state_next = ST_CTEST;
                end
            end
            // Depth test and write.
            ST_CTEST:
            begin
                if (rd_depth < z_reg)
                begin
                    ram_we = 1'b1;
                end
                if (col_reg == hi_reg)
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = ST_ROW;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    state_next = ST_CMUL;
                end
            end
            // Pixel read.
            ST_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = pidx_ext[ADDR_W-1:0];
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                if (32'(pidx_reg) < 32'(STORE_SIZE))
                begin
                    rc_next  = ram_rdata[WORD_W-1:COORD_W];
                    rdp_next = rd_depth;
                end
                state_next = ST_DONE;
            end
            // Hand the result to the output register once it is free.
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_color_next = rc_reg;
                    out_depth_next = rdp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            sw_reg        <= SW_RST;
            sh_reg        <= SH_RST;
            map_cnt_reg   <= '0;
            row_reg       <= '0;
            k_reg         <= '0;
            col_reg       <= '0;
            hi_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_op_reg    <= clr_op_next;
            out_valid_reg <= out_valid_next;
            sw_reg        <= sw_next;
            sh_reg        <= sh_next;
            map_cnt_reg   <= map_cnt_next;
            row_reg       <= row_next;
            k_reg         <= k_next;
            col_reg       <= col_next;
            hi_reg        <= hi_next;
        end
    end

    // Datapath registers and the shared multiplier.
    always_ff @(posedge clk)
    begin
        prod_reg      <= mul_a * mul_b;
        tmp_reg       <= tmp_next;
        rv0_reg       <= rv0_next;
        rv1_reg       <= rv1_next;
        rv2_reg       <= rv2_next;
        color_reg     <= color_next;
        pidx_reg      <= pidx_next;
        p0_reg        <= p0_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        s0_reg        <= s0_next;
        s1_reg        <= s1_next;
        s2_reg        <= s2_next;
        d1_reg        <= d1_next;
        total_reg     <= total_next;
        seg_reg       <= seg_next;
        ax_reg        <= ax_next;
        bx_reg        <= bx_next;
        az_reg        <= az_next;
        bz_reg        <= bz_next;
        z_reg         <= z_next;
        base_reg      <= base_next;
        rc_reg        <= rc_next;
        rdp_reg       <= rdp_next;
        out_color_reg <= out_color_next;
        out_depth_reg <= out_depth_next;
    end

    assign cmd.ready       = cmd_ready;
    assign res.valid       = out_valid_reg;
    assign res.pixel_color = out_color_reg;
    assign res.pixel_depth = out_depth_reg;

`ifndef SYNTHESIS
    // A command transaction takes the sequencer out of idle, so the command channel drops ready.
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command channel ready right after a transaction");

    // A result is only presented out of the done state.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res.valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the done state");

    // The divider is never restarted while it works.
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // Every tested pixel lies inside the clamped span and the screen row.
    a_col_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CTEST) |-> ((col_reg <= hi_reg) && (col_reg < sw_reg)))
        else $error("pixel column outside the span");
`endif
endmodule

`default_nettype wire

@@ design/trzb_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module trzb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

`default_nettype wire

@@ design/trzb_rnd_div.sv @@
// Bit-serial divider giving round(n / d) with halves rounded away from zero.
// Depends on trzb_pkg.
`default_nettype none

module trzb_rnd_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic signed [trzb_pkg::NUM_W-1:0] n,
    input  wire logic [trzb_pkg::PX_W-1:0]        d,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [trzb_pkg::Q_W-1:0]       q
);
    import trzb_pkg::*;

    localparam int ACC_W = NUM_W + 1;
    localparam int CNT_W = $clog2(ACC_W + 1);

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [PX_W:0]    rem_reg, rem_next;
    logic [PX_W:0]    den_reg, den_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [NUM_W-1:0] mag;
    logic [PX_W+1:0]  rem_sh;
    logic             ge;

    // One quotient bit per cycle on the numerator 2|n| + d over 2d.
    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        mag       = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
        rem_sh    = {rem_reg, acc_reg[ACC_W-1]};
        ge        = rem_sh >= {1'b0, den_reg};
        if (start)
        begin
            acc_next  = {mag, 1'b0} + ACC_W'(d);
            den_next  = {d, 1'b0};
            rem_next  = '0;
            neg_next  = n[NUM_W-1];
            cnt_next  = CNT_W'(ACC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (PX_W+1)'(rem_sh - {1'b0, den_reg}) : (PX_W+1)'(rem_sh);
            acc_next = {acc_reg[ACC_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign q    = neg_reg ? -$signed(acc_reg[Q_W-1:0]) : $signed(acc_reg[Q_W-1:0]);
endmodule

`default_nettype wire
